### rtl/dynamic_cube_point_counter_assert.svh
// ----------------------------------------------------------------------------
// Point counter assertion macros
// Shared property forms for the checker: same-cycle and next-cycle rules.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_CUBE_POINT_COUNTER_ASSERT_SVH
`define DYNAMIC_CUBE_POINT_COUNTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DCPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dcpc_pkg.sv
// ----------------------------------------------------------------------------
// dcpc_pkg
// Shared sizes, command codes, store entry layout and control structs.
// ----------------------------------------------------------------------------
package dcpc_pkg;

	// store size and derived widths
	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam int COORD_W = 16;
	localparam int COUNT_W = 12;
	localparam int CMD_W   = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// one stored point; neg set means weight -1
	typedef struct packed {
		logic               neg;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_POST
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic upd_en;      // non-query beat taken, apply store update
		logic q_start;     // query beat taken, latch bounds, clear sum
		logic rd_en;       // read next store entry
		logic out_load;    // load result register
		logic out_direct;  // result comes straight from the incoming beat
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_query;
		logic empty;
		logic scan_last;
		logic pipe_busy;
	} dp_stat_t;

endpackage

### rtl/dcpc_if.sv
// ----------------------------------------------------------------------------
// dcpc request and response channels
// Valid/ready channels carrying one command beat and one result beat.
// ----------------------------------------------------------------------------
interface dcpc_req_if
	import dcpc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;
	logic [COORD_W-1:0] pz;
	logic [COORD_W-1:0] side;

	modport source (output valid, cmd, px, py, pz, side, input ready);
	modport sink   (input valid, cmd, px, py, pz, side, output ready);
endinterface

interface dcpc_rsp_if
	import dcpc_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic signed [COUNT_W-1:0] count;

	modport source (output valid, status, count, input ready);
	modport sink   (input valid, status, count, output ready);
endinterface

### rtl/dcpc_ctrl.sv
// ----------------------------------------------------------------------------
// dcpc_ctrl
// Sequencer: takes a beat, runs the store scan for queries, posts the result.
// ----------------------------------------------------------------------------
module dcpc_ctrl
	import dcpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (stat.is_query) begin
						cmd.q_start = 1'b1;
						state_d     = stat.empty ? ST_DRAIN : ST_SCAN;
					end else begin
						cmd.upd_en = 1'b1;
						if (slot_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_direct = 1'b1;
						end else begin
							state_d = ST_POST;
						end
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/dcpc_datapath.sv
// ----------------------------------------------------------------------------
// dcpc_datapath
// Point store, fill count, last point, scan pipeline and result register.
// ----------------------------------------------------------------------------
module dcpc_datapath
	import dcpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic [CMD_W-1:0]          req_cmd,
	input  logic [COORD_W-1:0]        req_px,
	input  logic [COORD_W-1:0]        req_py,
	input  logic [COORD_W-1:0]        req_pz,
	input  logic [COORD_W-1:0]        req_side,
	output logic                      rsp_status,
	output logic signed [COUNT_W-1:0] rsp_count
);

	entry_t mem [STORE_DEPTH];

	logic [CNT_W-1:0]   entry_count_q;
	logic [COORD_W-1:0] last_x_q, last_y_q, last_z_q;
	logic [ADDR_W-1:0]  idx_q;

	// query bounds, upper bounds one bit wider so they never wrap
	logic [COORD_W-1:0] lo_x_q, lo_y_q, lo_z_q;
	logic [COORD_W:0]   hi_x_q, hi_y_q, hi_z_q;

	logic               v_s1, v_s2;
	entry_t             rd_s1;
	logic               hit_s2, neg_s2;
	logic               hit;

	logic [COUNT_W-1:0] acc_q;
	logic               res_status_q;

	logic               full;
	logic               is_store;
	logic               do_write;
	logic               st_now;
	entry_t             wr_entry;

	assign full     = (entry_count_q == CNT_W'(STORE_DEPTH));
	assign is_store = (req_cmd == CMD_ADD) || (req_cmd == CMD_CANCEL);
	assign st_now   = full && is_store;
	assign do_write = cmd.upd_en && is_store && !full;

	// cancel stores the last added point with negative weight
	always_comb begin
		if (req_cmd == CMD_ADD) begin
			wr_entry = '{neg: 1'b0, x: req_px, y: req_py, z: req_pz};
		end else begin
			wr_entry = '{neg: 1'b1, x: last_x_q, y: last_y_q, z: last_z_q};
		end
	end

	// status to controller
	assign stat.is_query  = (req_cmd == CMD_QUERY);
	assign stat.empty     = (entry_count_q == '0);
	assign stat.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == entry_count_q);
	assign stat.pipe_busy = v_s1 || v_s2;

	// store write port
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[entry_count_q[ADDR_W-1:0]] <= wr_entry;
		end
	end

	// store read port, registered data
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem[idx_q];
		end
	end

	// fill count, last added point, scan index, pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			last_z_q      <= '0;
			idx_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			if (do_write) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
				if (req_cmd == CMD_ADD) begin
					last_x_q <= req_px;
					last_y_q <= req_py;
					last_z_q <= req_pz;
				end
			end
			if (cmd.q_start) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	// latch cube bounds at query start
	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			lo_x_q <= req_px;
			lo_y_q <= req_py;
			lo_z_q <= req_pz;
			hi_x_q <= {1'b0, req_px} + {1'b0, req_side};
			hi_y_q <= {1'b0, req_py} + {1'b0, req_side};
			hi_z_q <= {1'b0, req_pz} + {1'b0, req_side};
		end
	end

	// inclusive cube test on the entry just read
	assign hit = (rd_s1.x >= lo_x_q) && ({1'b0, rd_s1.x} <= hi_x_q) &&
	             (rd_s1.y >= lo_y_q) && ({1'b0, rd_s1.y} <= hi_y_q) &&
	             (rd_s1.z >= lo_z_q) && ({1'b0, rd_s1.z} <= hi_z_q);

	always_ff @(posedge clk) begin
		hit_s2 <= hit;
		neg_s2 <= rd_s1.neg;
	end

	// weighted sum, wraps in the count width
	always_ff @(posedge clk) begin
		if (cmd.q_start || cmd.upd_en) begin
			acc_q        <= '0;
			res_status_q <= st_now && cmd.upd_en;
		end else if (v_s2 && hit_s2) begin
			acc_q <= neg_s2 ? (acc_q - COUNT_W'(1)) : (acc_q + COUNT_W'(1));
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_direct) begin
				rsp_status <= st_now;
				rsp_count  <= '0;
			end else begin
				rsp_status <= res_status_q;
				rsp_count  <= $signed(acc_q);
			end
		end
	end

endmodule

### rtl/dynamic_cube_point_counter.sv
// ----------------------------------------------------------------------------
// dynamic_cube_point_counter
// Store of weighted 3D points with add, cancel and inclusive cube count.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   cmd, px, py, pz, side
//  rsp      out  status, count
//
//  Add, cancel and unused codes are answered straight from the incoming beat
//  when the result slot is free. A query scans one store entry per cycle,
//  via the single read port of the point store, into two pipeline stages.
//  Reset clears the fill count and last added point; the store needs no pass.
//  A stalled rsp holds its beat; req is taken again once the block is idle.
// ----------------------------------------------------------------------------
module dynamic_cube_point_counter
	import dcpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dcpc_req_if.sink   req,
	dcpc_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	dcpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// store and scan datapath
	dcpc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_cmd    (req.cmd),
		.req_px     (req.px),
		.req_py     (req.py),
		.req_pz     (req.pz),
		.req_side   (req.side),
		.rsp_status (rsp.status),
		.rsp_count  (rsp.count)
	);

endmodule

### rtl/dcpc_checker.sv
// ----------------------------------------------------------------------------
// dcpc_checker
// Port-level checks on the point counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "dynamic_cube_point_counter_assert.svh"

module dcpc_checker
	import dcpc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic [CMD_W-1:0]          req_cmd,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_status,
	input logic signed [COUNT_W-1:0] rsp_count
);

	// stalled result beat stays put
	`DCPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
	`DCPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_count), "rsp beat changed while stalled")

	// a query occupies the block, so no beat is taken right after it
	`DCPC_ASSERT_NEXT(a_query_busy, req_valid && req_ready && (req_cmd == CMD_QUERY), !req_ready, "req taken during scan")

	// a dropped item never carries a count
	`DCPC_ASSERT_NOW(a_full_zero, rsp_valid && rsp_status, rsp_count == '0, "full status with nonzero count")

endmodule

bind dynamic_cube_point_counter dcpc_checker u_dcpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_cmd    (req.cmd),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

### verif/dcpc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcpc_result_checker
// Watches the request and response channels of the point counter. Every
// accepted request beat is applied to a private copy of the point store and queues
// the result it should produce; every accepted response beat is compared,
// field by field, with the oldest queued result.
// ----------------------------------------------------------------------------
module dcpc_result_checker
	import dcpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dcpc_req_if  req,
	dcpc_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic                      status;
		logic signed [COUNT_W-1:0] count;
	} result_t;

	entry_t             pts [STORE_DEPTH];
	int unsigned        n_pts = 0;
	logic [COORD_W-1:0] last_x = '0;
	logic [COORD_W-1:0] last_y = '0;
	logic [COORD_W-1:0] last_z = '0;
	result_t            exp_q [$];
	int                 n_fail = 0;

	// inclusive span test, upper bound taken in 17 bits so it never wraps
	function automatic logic in_span(input logic [COORD_W-1:0] v, lo, ext);
		return ({1'b0, v} >= {1'b0, lo}) && ({1'b0, v} <= {1'b0, lo} + {1'b0, ext});
	endfunction

	// append one weighted point, zero when the store is already full
	function automatic logic store_point(input logic [COORD_W-1:0] x, y, z,
	                                     input logic neg);
		if (n_pts >= STORE_DEPTH)
			return 1'b0;
		pts[n_pts] = {neg, x, y, z};
		n_pts++;
		return 1'b1;
	endfunction

	// apply one command to the local store and return the result it gives
	function automatic result_t cube_count_result(input logic [CMD_W-1:0] cmd,
	                                              input logic [COORD_W-1:0] x, y, z, s);
		result_t r;
		int      acc;
		r   = '0;
		acc = 0;
		case (cmd)
			CMD_ADD: begin
				if (store_point(x, y, z, 1'b0)) begin
					last_x = x;
					last_y = y;
					last_z = z;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (!store_point(last_x, last_y, last_z, 1'b1))
					r.status = 1'b1;
			end
			CMD_QUERY: begin
				for (int i = 0; i < n_pts; i++) begin
					if (in_span(pts[i].x, x, s) && in_span(pts[i].y, y, s) &&
					    in_span(pts[i].z, z, s))
						acc += pts[i].neg ? -1 : 1;
				end
				r.count = acc[COUNT_W-1:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	// request beats queue predictions first, so a same-cycle result still finds one
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			n_pts  = 0;
			last_x = '0;
			last_y = '0;
			last_z = '0;
			exp_q.delete();
		end else begin
			if (req.valid && req.ready)
				exp_q.push_back(cube_count_result(req.cmd, req.px, req.py, req.pz, req.side));
			if (rsp.valid && rsp.ready) begin
				if (exp_q.size() == 0) begin
					n_fail++;
					$display("%0t: result beat with nothing expected, got status %0d count %0d",
					         $time, rsp.status, rsp.count);
				end else begin
					want = exp_q.pop_front();
					if (rsp.status !== want.status) begin
						n_fail++;
						$display("%0t: status mismatch, expected %0d got %0d",
						         $time, want.status, rsp.status);
					end
					if (rsp.count !== want.count) begin
						n_fail++;
						$display("%0t: count mismatch, expected %0d got %0d",
						         $time, want.count, rsp.count);
					end
				end
			end
		end
		pending    <= exp_q.size();
		fail_count <= n_fail;
	end

endmodule

### verif/dynamic_cube_point_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dynamic_cube_point_counter_tb
// Drives add, cancel, cube query and unused command beats into the point
// counter: a directed opening over edge coordinates and cube bounds, clustered
// random traffic so queries actually hit points, then a fill of the store
// until adds and cancels are dropped. Both channels idle at random; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dynamic_cube_point_counter_tb;
	import dcpc_pkg::*;

	localparam logic [CMD_W-1:0]   CMD_UNUSED     = 2'd3;
	localparam logic [COORD_W-1:0] COORD_MAX      = '1;
	localparam int                 RANDOM_ITEMS   = 580;
	localparam int                 CALM_ITEMS     = 80;
	localparam int                 HOLDOFF_AT     = 200;
	localparam int                 DRAIN_AT       = 380;
	localparam int                 HOLDOFF_CYCLES = 400;
	localparam int                 IDLE_PCT       = 37;
	localparam int                 STALL_LIMIT    = 20000;

	logic               clk;
	logic               arst_n;
	int                 fail_count;
	int                 pending;
	int                 stored;
	int                 idle_cycles = 0;
	bit                 gaps_on;
	bit                 stalls_on;
	bit                 holdoff_req;
	logic [COORD_W-1:0] bx, by, bz;

	dcpc_req_if req ();
	dcpc_rsp_if rsp ();

	dynamic_cube_point_counter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	dcpc_result_checker count_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stalls, or one long hold-off when asked
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				rsp.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_req = 1'b0;
			end else begin
				rsp.ready <= !(stalls_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// corner of a point cluster; now and then right at the top of the space
	function automatic logic [COORD_W-1:0] cluster_base();
		if ($urandom_range(0, 7) == 0)
			return COORD_W'($urandom_range(65504, 65535));
		return COORD_W'($urandom);
	endfunction

	// coordinate near a cluster corner, with some fully random and edge values
	function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] b,
	                                            input int spread);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return COORD_W'($urandom);
		if (r < 13)
			return ($urandom_range(0, 1) != 0) ? COORD_MAX : '0;
		return b + COORD_W'($urandom_range(0, spread));
	endfunction

	// one request beat, with an optional idle gap ahead of it
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] x, y, z, s);
		if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= c;
		req.px    <= x;
		req.py    <= y;
		req.pz    <= z;
		req.side  <= s;
		do @(posedge clk); while (!req.ready);
		if ((c == CMD_ADD || c == CMD_CANCEL) && stored < STORE_DEPTH)
			stored++;
	endtask

	// random beat from the given mix; what is left over goes to the unused code
	task automatic send_random_beat(input int add_pct, cancel_pct, query_pct);
		int unsigned        r;
		logic [COORD_W-1:0] s;
		if ($urandom_range(0, 39) == 0) begin
			bx = cluster_base();
			by = cluster_base();
			bz = cluster_base();
		end
		r = $urandom_range(0, 99);
		if (r < add_pct) begin
			send_beat(CMD_ADD, near(bx, 31), near(by, 31), near(bz, 31), COORD_W'($urandom));
		end else if (r < add_pct + cancel_pct) begin
			send_beat(CMD_CANCEL, COORD_W'($urandom), COORD_W'($urandom),
			          COORD_W'($urandom), COORD_W'($urandom));
		end else if (r < add_pct + cancel_pct + query_pct) begin
			case ($urandom_range(0, 9))
				0: s = COORD_MAX;
				1: s = COORD_W'($urandom);
				default: s = COORD_W'($urandom_range(0, 24));
			endcase
			send_beat(CMD_QUERY, near(bx, 20), near(by, 20), near(bz, 20), s);
		end else begin
			send_beat(CMD_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
			          COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.cmd     = CMD_ADD;
		req.px      = '0;
		req.py      = '0;
		req.pz      = '0;
		req.side    = '0;
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		holdoff_req = 1'b0;
		stored      = 0;
		bx          = cluster_base();
		by          = cluster_base();
		bz          = cluster_base();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, then a cancel that falls back on the reset origin
		send_beat(CMD_QUERY, '0, '0, '0, COORD_MAX);
		send_beat(CMD_CANCEL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_beat(CMD_QUERY, '0, '0, '0, '0);
		// corner points of the space; the top query runs past 65535 without wrapping
		send_beat(CMD_ADD, '0, '0, '0, COORD_MAX);
		send_beat(CMD_ADD, COORD_MAX, COORD_MAX, COORD_MAX, '0);
		send_beat(CMD_ADD, COORD_MAX, '0, COORD_MAX, '0);
		send_beat(CMD_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_beat(CMD_CANCEL, '0, '0, '0, '0);
		send_beat(CMD_QUERY, '0, '0, '0, COORD_MAX);
		// unused code leaves the store alone
		send_beat(CMD_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_beat(CMD_UNUSED, '0, '0, '0, '0);
		// inclusive bounds around one point
		send_beat(CMD_ADD, 16'h1234, 16'hABCD, 16'h5555, 16'hAAAA);
		send_beat(CMD_QUERY, 16'h1234, 16'hABCD, 16'h5555, '0);
		send_beat(CMD_QUERY, 16'h1235, 16'hABCD, 16'h5555, 16'h0010);
		send_beat(CMD_QUERY, 16'h1233, 16'hABCC, 16'h5554, 16'h0001);
		send_beat(CMD_QUERY, 16'h1233, 16'hABCD, 16'h5555, '0);
		send_beat(CMD_CANCEL, '0, '0, '0, '0);
		send_beat(CMD_QUERY, 16'h1234, 16'hABCD, 16'h5555, '0);

		// clustered random traffic; opens with a stretch free of idling
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == CALM_ITEMS) begin
				gaps_on   = 1'b1;
				stalls_on = 1'b1;
			end
			if (i == HOLDOFF_AT)
				holdoff_req = 1'b1;
			if (i == DRAIN_AT)
				wait_drained();
			send_random_beat(50, 15, 30);
		end

		// fill the store, mostly adds with a few queries over the growing store
		while (stored < STORE_DEPTH)
			send_random_beat(85, 12, 2);

		// store full: adds and cancels are dropped, queries still scan everything
		send_beat(CMD_ADD, near(bx, 31), near(by, 31), near(bz, 31), '0);
		send_beat(CMD_CANCEL, '0, '0, '0, '0);
		send_beat(CMD_QUERY, '0, '0, '0, COORD_MAX);
		send_beat(CMD_UNUSED, COORD_MAX, '0, COORD_MAX, '0);
		send_beat(CMD_ADD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_beat(CMD_QUERY, bx, by, bz, 16'h0020);
		for (int i = 0; i < 6; i++)
			send_random_beat(40, 30, 25);

		wait_drained();
		repeat (STORE_DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/dcpc_pkg.sv
rtl/dcpc_if.sv
rtl/dcpc_ctrl.sv
rtl/dcpc_datapath.sv
rtl/dynamic_cube_point_counter.sv
rtl/dcpc_checker.sv
verif/dcpc_result_checker.sv
verif/dynamic_cube_point_counter_tb.sv
